>>> rtl/anxb_pkg.sv
`timescale 1ns / 1ps

package anxb_pkg;

	typedef enum logic [3:0] {
		PH_HEADER    = 4'd0,
		PH_NAL_HI    = 4'd1,
		PH_NAL_LO    = 4'd2,
		PH_PAYLOAD   = 4'd3,
		PH_PPS_COUNT = 4'd4,
		PH_ARR_TYPE  = 4'd5,
		PH_ARR_HI    = 4'd6,
		PH_ARR_LO    = 4'd7,
		PH_DONE      = 4'd8
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TOO_SHORT = 2'd1,
		ST_BAD_VER   = 2'd2,
		ST_TRUNC     = 2'd3
	} status_t;

	localparam logic       MODE_AVCC     = 1'b0;
	localparam logic [7:0] VERSION_ONE   = 8'h01;
	localparam logic [7:0] SC_LAST_BYTE  = 8'h01;
	localparam logic [4:0] POS_SAT       = 5'd23;
	localparam logic [4:0] AVC_POS_LS    = 5'd4;
	localparam logic [4:0] AVC_POS_NSPS  = 5'd5;
	localparam logic [4:0] AVC_MIN_LAST  = 5'd6;
	localparam logic [4:0] HVC_POS_LS    = 5'd21;
	localparam logic [4:0] HVC_POS_NARR  = 5'd22;
	localparam logic [4:0] HVC_MIN_LAST  = 5'd22;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic       is_status;
		logic [7:0] out_byte;
		logic [1:0] status_code;
		logic [2:0] prefix_len;
		logic       run_end;
	} out_item_t;

	// everything one input byte produces: start code, payload byte, status
	typedef struct packed {
		logic       sc;
		logic       byte_en;
		logic [7:0] data;
		logic       st;
		status_t    code;
		logic [2:0] ls;
	} bundle_t;

endpackage

>>> rtl/anxb_parser.sv
`timescale 1ns / 1ps

module anxb_parser import anxb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       mode,
	input  logic       fire,
	input  in_item_t   item,
	output bundle_t    bundle
);

	phase_t      phase_q, ph_n;
	logic [4:0]  pos_q, pos_n;
	logic [2:0]  ps_q, ps_n;
	logic [7:0]  outer_q, outer_n;
	logic [15:0] inner_q, inner_n;
	logic [15:0] pay_q, pay_n;
	logic [7:0]  hb_q, hb_n;
	logic        vb_q, vb_n;

	function automatic phase_t group_end(input logic m, input logic [7:0] outer);
		if (m != MODE_AVCC) begin
			return (outer != 8'd0) ? PH_ARR_TYPE : PH_DONE;
		end
		return (outer != 8'd0) ? PH_PPS_COUNT : PH_DONE;
	endfunction

	always_comb begin
		logic [7:0] b;
		b       = item.data_byte;
		ph_n    = phase_q;
		ps_n    = ps_q;
		outer_n = outer_q;
		inner_n = inner_q;
		pay_n   = pay_q;
		hb_n    = hb_q;
		vb_n    = vb_q;
		bundle  = '0;
		bundle.data = b;

		unique case (phase_q)
			PH_HEADER: begin
				if (pos_q == 5'd0) vb_n = (b != VERSION_ONE);
				if (mode == MODE_AVCC) begin
					if (pos_q == AVC_POS_LS) ps_n = {1'b0, b[1:0]} + 3'd1;
					if (pos_q == AVC_POS_NSPS) begin
						inner_n = {11'd0, b[4:0]};
						outer_n = 8'd1;
						if (vb_n) begin
							ph_n = PH_DONE;
						end else if (inner_n == 16'd0) begin
							ph_n    = group_end(mode, outer_n);
							outer_n = 8'd0;
						end else begin
							ph_n = PH_NAL_HI;
						end
					end
				end else begin
					if (pos_q == HVC_POS_LS) ps_n = {1'b0, b[1:0]} + 3'd1;
					if (pos_q == HVC_POS_NARR) begin
						outer_n = b;
						if (vb_n) ph_n = PH_DONE;
						else ph_n = (b != 8'd0) ? PH_ARR_TYPE : PH_DONE;
					end
				end
			end
			PH_NAL_HI: begin
				hb_n = b;
				ph_n = PH_NAL_LO;
			end
			PH_NAL_LO: begin
				pay_n     = {hb_q, b};
				inner_n   = inner_q - 16'd1;
				bundle.sc = 1'b1;
				if (pay_n != 16'd0) begin
					ph_n = PH_PAYLOAD;
				end else if (inner_n == 16'd0) begin
					ph_n = group_end(mode, outer_q);
					if (mode == MODE_AVCC) outer_n = 8'd0;
				end else begin
					ph_n = PH_NAL_HI;
				end
			end
			PH_PAYLOAD: begin
				bundle.byte_en = 1'b1;
				pay_n = pay_q - 16'd1;
				if (pay_n == 16'd0) begin
					if (inner_q == 16'd0) begin
						ph_n = group_end(mode, outer_q);
						if (mode == MODE_AVCC) outer_n = 8'd0;
					end else begin
						ph_n = PH_NAL_HI;
					end
				end
			end
			PH_PPS_COUNT: begin
				inner_n = {8'd0, b};
				outer_n = 8'd0;
				ph_n    = (b == 8'd0) ? group_end(mode, 8'd0) : PH_NAL_HI;
			end
			PH_ARR_TYPE: begin
				outer_n = outer_q - 8'd1;
				ph_n    = PH_ARR_HI;
			end
			PH_ARR_HI: begin
				hb_n = b;
				ph_n = PH_ARR_LO;
			end
			PH_ARR_LO: begin
				inner_n = {hb_q, b};
				if (inner_n == 16'd0) begin
					ph_n = group_end(mode, outer_q);
					if (mode == MODE_AVCC) outer_n = 8'd0;
				end else begin
					ph_n = PH_NAL_HI;
				end
			end
			default: begin
			end
		endcase

		pos_n = (pos_q < POS_SAT) ? pos_q + 5'd1 : pos_q;

		if (item.last_byte) begin
			bundle.st = 1'b1;
			if (pos_q < ((mode != MODE_AVCC) ? HVC_MIN_LAST : AVC_MIN_LAST)) begin
				bundle.code = ST_TOO_SHORT;
			end else if (vb_n) begin
				bundle.code = ST_BAD_VER;
			end else begin
				bundle.code = (ph_n == PH_DONE || ph_n == PH_PPS_COUNT) ? ST_OK : ST_TRUNC;
				bundle.ls   = ps_n;
			end
			// record closed: back to a fresh parse
			ph_n    = PH_HEADER;
			pos_n   = 5'd0;
			ps_n    = 3'd0;
			outer_n = 8'd0;
			inner_n = 16'd0;
			pay_n   = 16'd0;
			hb_n    = 8'd0;
			vb_n    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= 5'd0;
			ps_q    <= 3'd0;
			outer_q <= 8'd0;
			inner_q <= 16'd0;
			pay_q   <= 16'd0;
			hb_q    <= 8'd0;
			vb_q    <= 1'b0;
		end else if (fire) begin
			phase_q <= ph_n;
			pos_q   <= pos_n;
			ps_q    <= ps_n;
			outer_q <= outer_n;
			inner_q <= inner_n;
			pay_q   <= pay_n;
			hb_q    <= hb_n;
			vb_q    <= vb_n;
		end
	end

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.last_byte |=> phase_q == PH_HEADER && pos_q == 5'd0)
		else $error("parse state not cleared after last beat");

	a_header_pos: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_HEADER |-> pos_q >= AVC_MIN_LAST)
		else $error("left header before length field");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!(bundle.sc && bundle.byte_en))
		else $error("start code and payload byte from one beat");

endmodule

>>> rtl/anxb_emitter.sv
`timescale 1ns / 1ps

module anxb_emitter import anxb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  bundle_t   bundle,
	output logic      free,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	bundle_t    bun_q;
	logic       res_valid_q;
	logic [2:0] idx_q;
	logic [2:0] n_data;
	logic [2:0] total;
	logic       item_last;

	assign n_data    = bun_q.sc ? 3'd4 : (bun_q.byte_en ? 3'd1 : 3'd0);
	assign total     = n_data + {2'b0, bun_q.st};
	assign item_last = (idx_q == total - 3'd1);
	assign free      = !res_valid_q || (out_ready && item_last);
	assign out_valid = res_valid_q;

	always_comb begin
		out_item = '0;
		out_item.run_end = item_last;
		if (idx_q < n_data) begin
			if (bun_q.sc) out_item.out_byte = (idx_q == 3'd3) ? SC_LAST_BYTE : 8'h00;
			else out_item.out_byte = bun_q.data;
		end else begin
			out_item.is_status   = 1'b1;
			out_item.status_code = bun_q.code;
			out_item.prefix_len  = bun_q.ls;
		end
	end

	always_ff @(posedge clk) begin
		if (load) bun_q <= bundle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			idx_q       <= 3'd0;
		end else if (load) begin
			res_valid_q <= 1'b1;
			idx_q       <= 3'd0;
		end else if (res_valid_q && out_ready) begin
			if (item_last) res_valid_q <= 1'b0;
			else idx_q <= idx_q + 3'd1;
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("result register overwritten");

	a_status_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.is_status |-> out_item.run_end)
		else $error("status beat not last of its group");

	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.is_status |->
			out_item.status_code == ST_OK && out_item.prefix_len == 3'd0)
		else $error("data beat carries status fields");

	a_short_no_ls: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.is_status &&
			(out_item.status_code == ST_TOO_SHORT || out_item.status_code == ST_BAD_VER)
			|-> out_item.prefix_len == 3'd0)
		else $error("length size on failed header");

endmodule

>>> rtl/avcc_hvcc_to_annexb_converter.sv
`timescale 1ns / 1ps
// an accepted byte is registered in the input stage; its beats are registered in the result register once that is free
// throughput: one byte per cycle while out_ready holds; a byte that closes a NAL length yields four beats
//   (the start code), and the byte flagged last adds one status beat
// the result register holds the beats of one byte and reloads in the cycle its last beat leaves
// reset: async active low, clears parse state, pipeline valids and codec_mode to avcC

module avcc_hvcc_to_annexb_converter import anxb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	in_item_t in_s1;
	logic     valid_s1;
	logic     codec_mode_q;
	logic     free;
	logic     advance;
	logic     load;
	bundle_t  bundle;

	assign advance  = valid_s1 && free;
	assign load     = advance && (bundle.sc || bundle.byte_en || bundle.st);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codec_mode_q <= MODE_AVCC;
		end else if (cfg_we) begin
			codec_mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) in_s1 <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	anxb_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.mode   (codec_mode_q),
		.fire   (advance),
		.item   (in_s1),
		.bundle (bundle)
	);

	anxb_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.bundle    (bundle),
		.free      (free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !free |=> valid_s1 && $stable(in_s1))
		else $error("staged beat lost while output stalled");

	a_last_status: assert property (@(posedge clk) disable iff (!arst_n)
		advance && in_s1.last_byte |=> out_valid)
		else $error("last beat produced no status");

endmodule

>>> verif/avcc_hvcc_to_annexb_converter_tb.sv
`timescale 1ns / 1ps

module avcc_hvcc_to_annexb_converter_tb;
	import anxb_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE = 8;
	localparam int MAX_REPORTS = 10;
	localparam int ITEMS_PER_MIX = 32;

	typedef struct packed {
		logic       mode;
		logic [7:0] data;
		logic       lst;
		logic       typed;
		status_t    code;
		logic [2:0] ls;
	} dir_row_t;

	// directed records: short avcC, bad version, full avcC with zero-length sps,
	// one pps and a trailing byte, short hvcC
	localparam dir_row_t DIR_ROWS [23] = '{
		'{1'b0, 8'hFF, 1'b1, 1'b1, ST_TOO_SHORT, 3'd0},
		'{1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 3'd0},
		'{1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 3'd0},
		'{1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 3'd0},
		'{1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 3'd0},
		'{1'b0, 8'h03, 1'b0, 1'b0, ST_OK, 3'd0},
		'{1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 3'd0},
		'{1'b0, 8'h00, 1'b1, 1'b1, ST_BAD_VER, 3'd0},
		'{1'b0, 8'h01, 1'b0, 1'b0, ST_OK, 3'd0},
		'{1'b0, 8'h64, 1'b0, 1'b0, ST_OK, 3'd0},
		'{1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 3'd0},
		'{1'b0, 8'h1F, 1'b0, 1'b0, ST_OK, 3'd0},
		'{1'b0, 8'hFC, 1'b0, 1'b0, ST_OK, 3'd0},
		'{1'b0, 8'h01, 1'b0, 1'b0, ST_OK, 3'd0},
		'{1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 3'd0},
		'{1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 3'd0},
		'{1'b0, 8'h01, 1'b0, 1'b0, ST_OK, 3'd0},
		'{1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 3'd0},
		'{1'b0, 8'h02, 1'b0, 1'b0, ST_OK, 3'd0},
		'{1'b0, 8'h80, 1'b0, 1'b0, ST_OK, 3'd0},
		'{1'b0, 8'h7F, 1'b0, 1'b0, ST_OK, 3'd0},
		'{1'b0, 8'hEE, 1'b1, 1'b1, ST_OK, 3'd1},
		'{1'b1, 8'h01, 1'b1, 1'b1, ST_TOO_SHORT, 3'd0}
	};

	logic      clk;
	logic      arst_n = 1'b0;
	logic      cfg_we = 1'b0;
	logic      cfg_wdata = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;

	// converter state as the checker sees it
	logic        cv_mode;
	phase_t      cv_phase;
	logic [4:0]  cv_pos;
	logic [2:0]  cv_prefix;
	logic [7:0]  cv_arrays_left;
	logic [15:0] cv_nals_left;
	logic [15:0] cv_payload_left;
	logic [7:0]  cv_len_hi;
	logic        cv_ver_bad;

	out_item_t beats_due [$];

	int unsigned cycles = 0;
	int errors = 0;
	int beats_seen = 0;
	int items_fed = 0;
	int records = 0;
	int status_seen [4] = '{0, 0, 0, 0};
	int idle_pct = 0;
	int stall_pct = 0;

	avcc_hvcc_to_annexb_converter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic void clear_parse();
		cv_phase = PH_HEADER;
		cv_pos = '0;
		cv_prefix = '0;
		cv_arrays_left = '0;
		cv_nals_left = '0;
		cv_payload_left = '0;
		cv_len_hi = '0;
		cv_ver_bad = 1'b0;
	endfunction

	function automatic void push_beat(input logic is_st, input logic [7:0] b,
			input logic [1:0] code, input logic [2:0] ls);
		beats_due.push_back(out_item_t'{is_st, b, code, ls, 1'b0});
	endfunction

	// end of an sps/pps group or of an hvcC array
	function automatic void close_group();
		if (cv_mode != MODE_AVCC) begin
			if (cv_arrays_left != 8'd0)
				cv_phase = PH_ARR_TYPE;
			else
				cv_phase = PH_DONE;
		end else if (cv_arrays_left != 8'd0) begin
			cv_arrays_left = '0;
			cv_phase = PH_PPS_COUNT;
		end else begin
			cv_phase = PH_DONE;
		end
	endfunction

	function automatic void next_nal();
		if (cv_nals_left == 16'd0)
			close_group();
		else
			cv_phase = PH_NAL_HI;
	endfunction

	function automatic void convert_byte(input in_item_t it);
		logic [7:0] b;
		logic [4:0] pos;
		int n0;
		status_t code;
		logic [2:0] ls;
		out_item_t tail;
		b = it.data_byte;
		pos = cv_pos;
		n0 = beats_due.size();
		case (cv_phase)
			PH_HEADER: begin
				if (pos == 5'd0)
					cv_ver_bad = (b != VERSION_ONE);
				if (cv_mode == MODE_AVCC) begin
					if (pos == AVC_POS_LS)
						cv_prefix = {1'b0, b[1:0]} + 3'd1;
					if (pos == AVC_POS_NSPS) begin
						cv_nals_left = {11'd0, b[4:0]};
						cv_arrays_left = 8'd1;
						if (cv_ver_bad)
							cv_phase = PH_DONE;
						else
							next_nal();
					end
				end else begin
					if (pos == HVC_POS_LS)
						cv_prefix = {1'b0, b[1:0]} + 3'd1;
					if (pos == HVC_POS_NARR) begin
						cv_arrays_left = b;
						if (cv_ver_bad || b == 8'd0)
							cv_phase = PH_DONE;
						else
							cv_phase = PH_ARR_TYPE;
					end
				end
			end
			PH_NAL_HI: begin
				cv_len_hi = b;
				cv_phase = PH_NAL_LO;
			end
			PH_NAL_LO: begin
				cv_payload_left = {cv_len_hi, b};
				cv_nals_left = cv_nals_left - 16'd1;
				push_beat(1'b0, 8'h00, ST_OK, 3'd0);
				push_beat(1'b0, 8'h00, ST_OK, 3'd0);
				push_beat(1'b0, 8'h00, ST_OK, 3'd0);
				push_beat(1'b0, SC_LAST_BYTE, ST_OK, 3'd0);
				if (cv_payload_left != 16'd0)
					cv_phase = PH_PAYLOAD;
				else
					next_nal();
			end
			PH_PAYLOAD: begin
				push_beat(1'b0, b, ST_OK, 3'd0);
				cv_payload_left = cv_payload_left - 16'd1;
				if (cv_payload_left == 16'd0)
					next_nal();
			end
			PH_PPS_COUNT: begin
				cv_nals_left = {8'd0, b};
				cv_arrays_left = '0;
				next_nal();
			end
			PH_ARR_TYPE: begin
				cv_arrays_left = cv_arrays_left - 8'd1;
				cv_phase = PH_ARR_HI;
			end
			PH_ARR_HI: begin
				cv_len_hi = b;
				cv_phase = PH_ARR_LO;
			end
			PH_ARR_LO: begin
				cv_nals_left = {cv_len_hi, b};
				next_nal();
			end
			default: begin
			end
		endcase
		if (cv_pos < POS_SAT)
			cv_pos = cv_pos + 5'd1;
		if (it.last_byte) begin
			ls = 3'd0;
			if (pos < ((cv_mode != MODE_AVCC) ? HVC_MIN_LAST : AVC_MIN_LAST)) begin
				code = ST_TOO_SHORT;
			end else if (cv_ver_bad) begin
				code = ST_BAD_VER;
			end else begin
				if (cv_phase == PH_DONE || cv_phase == PH_PPS_COUNT)
					code = ST_OK;
				else
					code = ST_TRUNC;
				ls = cv_prefix;
			end
			push_beat(1'b1, 8'h00, code, ls);
			clear_parse();
		end
		if (beats_due.size() > n0) begin
			tail = beats_due.pop_back();
			tail.run_end = 1'b1;
			beats_due.push_back(tail);
		end
	endfunction

	function automatic void check_beat(input out_item_t got);
		out_item_t want;
		beats_seen++;
		if (beats_due.size() == 0) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("unexpected beat: st=%0d byte=%02h code=%0d ls=%0d end=%0d",
					got.is_status, got.out_byte, got.status_code, got.prefix_len, got.run_end);
		end else begin
			want = beats_due.pop_front();
			if (want.is_status)
				status_seen[want.status_code]++;
			if (got.is_status !== want.is_status || got.out_byte !== want.out_byte ||
					got.status_code !== want.status_code ||
					got.prefix_len !== want.prefix_len || got.run_end !== want.run_end) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("beat %0d: exp st=%0d byte=%02h code=%0d ls=%0d end=%0d, got st=%0d byte=%02h code=%0d ls=%0d end=%0d",
						beats_seen, want.is_status, want.out_byte, want.status_code,
						want.prefix_len, want.run_end, got.is_status, got.out_byte,
						got.status_code, got.prefix_len, got.run_end);
			end
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			check_beat(out_item);
	end

	// entered and left at a falling edge
	task automatic send_byte(input in_item_t it, input logic typed, input out_item_t want_st);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do
			@(posedge clk);
		while (!in_ready);
		items_fed++;
		convert_byte(it);
		if (typed) begin
			void'(beats_due.pop_back());
			beats_due.push_back(want_st);
		end
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (beats_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_mode(input logic m);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
		cv_mode = m;
	endtask

	task automatic add_nal(ref logic [7:0] rec [$]);
		int len;
		if ($urandom_range(99) < 3)
			len = $urandom_range(300, 256);
		else if ($urandom_range(99) < 10)
			len = $urandom_range(40, 7);
		else
			len = $urandom_range(6, 0);
		rec.push_back(8'(len >> 8));
		rec.push_back(8'(len));
		repeat (len) rec.push_back(8'($urandom));
	endtask

	task automatic build_record(input logic m, ref logic [7:0] rec [$]);
		int kind;
		int cnt;
		int arrays;
		rec.delete();
		kind = $urandom_range(99);
		if (kind < 20) begin
			// noise
			cnt = (m != MODE_AVCC) ? $urandom_range(30, 1) : $urandom_range(12, 1);
			repeat (cnt) rec.push_back(8'($urandom));
			if ($urandom_range(1) == 1)
				rec[0] = VERSION_ONE;
		end else begin
			rec.push_back(VERSION_ONE);
			if (m == MODE_AVCC) begin
				repeat (4) rec.push_back(8'($urandom));
				cnt = $urandom_range(3);
				rec.push_back({3'($urandom), 5'(cnt)});
				repeat (cnt) add_nal(rec);
				// otherwise the pps section is left out
				if ($urandom_range(99) < 75) begin
					cnt = $urandom_range(3);
					rec.push_back(8'(cnt));
					repeat (cnt) add_nal(rec);
				end
			end else begin
				repeat (21) rec.push_back(8'($urandom));
				arrays = $urandom_range(3);
				rec.push_back(8'(arrays));
				repeat (arrays) begin
					rec.push_back(8'($urandom));
					cnt = $urandom_range(3);
					rec.push_back(8'h00);
					rec.push_back(8'(cnt));
					repeat (cnt) add_nal(rec);
				end
			end
			if (kind < 30) begin
				rec[0] = ($urandom_range(1) == 1) ? 8'h00 : 8'($urandom_range(255, 2));
			end else if (kind < 45) begin
				rec = rec[0:$urandom_range(rec.size() - 2, 0)];
			end else if (kind < 60) begin
				repeat ($urandom_range(4, 1)) rec.push_back(8'($urandom));
			end
		end
		// long records end early, inside a payload or a later field
		if (rec.size() > 64)
			rec = rec[0:$urandom_range(63, 40)];
	endtask

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d beats still due", cycles, beats_due.size());
		$display("avcc_hvcc_to_annexb_converter_tb: done, errors");
		$finish;
	end

	initial begin
		int ph;
		int goal;
		int k;
		int r;
		logic [7:0] rec [$];
		out_item_t typed_st;
		cv_mode = MODE_AVCC;
		clear_parse();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		set_mode(MODE_AVCC);

		for (r = 0; r < 23; r++) begin
			if (DIR_ROWS[r].mode != cv_mode)
				set_mode(DIR_ROWS[r].mode);
			typed_st = '{1'b1, 8'h00, DIR_ROWS[r].code, DIR_ROWS[r].ls, 1'b1};
			send_byte('{DIR_ROWS[r].data, DIR_ROWS[r].lst}, DIR_ROWS[r].typed, typed_st);
		end

		// idling mixes: none, sender only, receiver only, both
		for (ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 46 : (ph == 3) ? 37 : 0;
			stall_pct = (ph == 2) ? 46 : (ph == 3) ? 37 : 0;
			goal = items_fed + ITEMS_PER_MIX;
			while (items_fed < goal) begin
				// codec mode flips between records, with the pipe drained
				if ($urandom_range(99) < 40)
					set_mode(!cv_mode);
				build_record(cv_mode, rec);
				for (k = 0; k < rec.size(); k++)
					send_byte('{rec[k], logic'(k == rec.size() - 1)}, 1'b0, '0);
				records++;
				// let the output run dry now and then
				if (records % 9 == 4)
					wait_idle();
			end
		end

		wait_idle();
		$display("%0d random records, %0d bytes fed, %0d beats checked, %0d mismatches",
			records, items_fed, beats_seen, errors);
		$display("status ok/short/version/truncated: %0d/%0d/%0d/%0d over both codec modes",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (errors == 0)
			$display("avcc_hvcc_to_annexb_converter_tb: done, clean");
		else
			$display("avcc_hvcc_to_annexb_converter_tb: done, errors");
		$finish;
	end

endmodule
